[design/csv_fs_pkg.sv]
// Shared types and constants for the CSV field splitter and type classifier.
`timescale 1ns / 1ps

package csv_fs_pkg;

  // Input item operation codes.
  typedef enum logic {
    OP_DATA = 1'b0,
    OP_EOL  = 1'b1
  } op_e;

  // Field type codes as reported in a result.
  typedef enum logic [2:0] {
    TYPE_NULL   = 3'd0,
    TYPE_STRING = 3'd1,
    TYPE_INT    = 3'd2,
    TYPE_FLOAT  = 3'd3,
    TYPE_BOOL   = 3'd4
  } field_type_e;

  // Per-field classification state, one-hot.
  typedef enum logic [8:0] {
    CLS_EMPTY   = 9'b000000001,
    CLS_SIGN    = 9'b000000010,
    CLS_INT     = 9'b000000100,
    CLS_FRAC    = 9'b000001000,
    CLS_EXP     = 9'b000010000,
    CLS_EXPTAIL = 9'b000100000,
    CLS_TRUE    = 9'b001000000,
    CLS_FALSE   = 9'b010000000,
    CLS_STR     = 9'b100000000
  } class_state_e;

  // Character codes.
  localparam logic [7:0] CH_COMMA   = 8'h2C;
  localparam logic [7:0] CH_QUOTE   = 8'h22;
  localparam logic [7:0] CH_NEWLINE = 8'h0A;
  localparam logic [7:0] CH_MINUS   = 8'h2D;
  localparam logic [7:0] CH_PLUS    = 8'h2B;
  localparam logic [7:0] CH_DOT     = 8'h2E;
  localparam logic [7:0] CH_LOW_E   = 8'h65;
  localparam logic [7:0] CH_UP_E    = 8'h45;
  localparam logic [7:0] CH_LOW_T   = 8'h74;
  localparam logic [7:0] CH_LOW_F   = 8'h66;
  localparam logic [7:0] CASE_BIT   = 8'h20;

  // Word lengths of the boolean literals.
  localparam logic [2:0] TRUE_LEN  = 3'd4;
  localparam logic [2:0] FALSE_LEN = 3'd5;

  // Integer accumulation limits: largest magnitude that can still take a digit,
  // and the magnitude of the most negative 64-bit value.
  localparam logic [63:0] ACC_GUARD = 64'd922337203685477580;
  localparam logic [63:0] MAG_LIMIT = 64'h8000_0000_0000_0000;
  localparam logic [63:0] POS_MAX   = 64'h7FFF_FFFF_FFFF_FFFF;

  // Input item.
  typedef struct packed {
    op_e        op;
    logic [7:0] data_byte;
  } csv_fs_in_t;

  // Type information of a closed field.
  typedef struct packed {
    field_type_e        field_type;
    logic signed [63:0] integer_value;
    logic               value_saturated;
    logic               boolean_value;
  } field_info_t;

  // Result item.
  typedef struct packed {
    logic [7:0]         column_index;
    logic               last_in_row;
    field_type_e        field_type;
    logic signed [63:0] integer_value;
    logic               value_saturated;
    logic               boolean_value;
  } csv_fs_out_t;

  // Letters of "true" by position (lower case).
  function automatic logic [7:0] true_char(input logic [2:0] idx);
    logic [7:0] c;
    case (idx)
      3'd0:    c = 8'h74;
      3'd1:    c = 8'h72;
      3'd2:    c = 8'h75;
      3'd3:    c = 8'h65;
      default: c = 8'h00;
    endcase
    return c;
  endfunction

  // Letters of "false" by position (lower case).
  function automatic logic [7:0] false_char(input logic [2:0] idx);
    logic [7:0] c;
    case (idx)
      3'd0:    c = 8'h66;
      3'd1:    c = 8'h61;
      3'd2:    c = 8'h6C;
      3'd3:    c = 8'h73;
      3'd4:    c = 8'h65;
      default: c = 8'h00;
    endcase
    return c;
  endfunction

endpackage

[design/csv_fs_field.sv]
// Per-field type classifier with integer accumulator and result formatting.
`timescale 1ns / 1ps

module csv_fs_field
  import csv_fs_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        step_i,
  input  logic        clear_i,
  input  logic [7:0]  byte_i,
  output field_info_t info_o
);

  class_state_e cls_q, cls_d;
  logic [2:0]   prog_q, prog_d;
  logic [63:0]  acc_q, acc_d;
  logic         neg_q, neg_d;
  logic         ovf_q, ovf_d;

  logic         is_digit, is_sign;
  logic [7:0]   low;
  logic [3:0]   digit;
  logic         add_en;
  logic [63:0]  acc_mul;

  assign is_digit = byte_i inside {[8'h30:8'h39]};
  assign is_sign  = (byte_i == CH_PLUS) || (byte_i == CH_MINUS);
  assign low      = byte_i | CASE_BIT;
  assign digit    = byte_i[3:0];

  // Multiply by ten and add the new digit.
  assign acc_mul = {acc_q[60:0], 3'b000} + {acc_q[62:0], 1'b0} + {60'd0, digit};

  // Next classification state for one text byte.
  always_comb begin
    cls_d  = cls_q;
    prog_d = prog_q;
    neg_d  = neg_q;
    add_en = 1'b0;
    case (cls_q)
      CLS_EMPTY: begin
        if (is_sign) begin
          cls_d = CLS_SIGN;
          neg_d = (byte_i == CH_MINUS);
        end else if (is_digit) begin
          cls_d  = CLS_INT;
          add_en = 1'b1;
        end else if (low == CH_LOW_T) begin
          cls_d  = CLS_TRUE;
          prog_d = 3'd1;
        end else if (low == CH_LOW_F) begin
          cls_d  = CLS_FALSE;
          prog_d = 3'd1;
        end else begin
          cls_d = CLS_STR;
        end
      end
      CLS_SIGN: begin
        if (is_digit) begin
          cls_d  = CLS_INT;
          add_en = 1'b1;
        end else begin
          cls_d = CLS_STR;
        end
      end
      CLS_INT: begin
        if (is_digit) begin
          add_en = 1'b1;
        end else if (byte_i == CH_DOT) begin
          cls_d = CLS_FRAC;
        end else begin
          cls_d = CLS_STR;
        end
      end
      CLS_FRAC: begin
        if ((byte_i == CH_LOW_E) || (byte_i == CH_UP_E)) begin
          cls_d = CLS_EXP;
        end else if (!is_digit) begin
          cls_d = CLS_STR;
        end
      end
      CLS_EXP: begin
        cls_d = (is_sign || is_digit) ? CLS_EXPTAIL : CLS_STR;
      end
      CLS_EXPTAIL: begin
        if (!is_digit) begin
          cls_d = CLS_STR;
        end
      end
      CLS_TRUE: begin
        if ((prog_q < TRUE_LEN) && (low == true_char(prog_q))) begin
          prog_d = prog_q + 3'd1;
        end else begin
          cls_d = CLS_STR;
        end
      end
      CLS_FALSE: begin
        if ((prog_q < FALSE_LEN) && (low == false_char(prog_q))) begin
          prog_d = prog_q + 3'd1;
        end else begin
          cls_d = CLS_STR;
        end
      end
      default: begin
        cls_d = CLS_STR;
      end
    endcase
  end

  // Digit accumulation with overflow tracking.
  always_comb begin
    acc_d = acc_q;
    ovf_d = ovf_q;
    if (add_en && !ovf_q) begin
      if (acc_q > ACC_GUARD) begin
        ovf_d = 1'b1;
      end else begin
        acc_d = acc_mul;
        ovf_d = (acc_mul > MAG_LIMIT);
      end
    end
  end

  // Field state registers; a field close returns them to the empty state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cls_q  <= CLS_EMPTY;
      prog_q <= 3'd0;
      acc_q  <= 64'd0;
      neg_q  <= 1'b0;
      ovf_q  <= 1'b0;
    end else if (clear_i) begin
      cls_q  <= CLS_EMPTY;
      prog_q <= 3'd0;
      acc_q  <= 64'd0;
      neg_q  <= 1'b0;
      ovf_q  <= 1'b0;
    end else if (step_i) begin
      cls_q  <= cls_d;
      prog_q <= prog_d;
      acc_q  <= acc_d;
      neg_q  <= neg_d;
      ovf_q  <= ovf_d;
    end
  end

  // Type and value of the field as it stands now.
  always_comb begin
    info_o.field_type      = TYPE_STRING;
    info_o.integer_value   = 64'sd0;
    info_o.value_saturated = 1'b0;
    info_o.boolean_value   = 1'b0;
    case (cls_q)
      CLS_EMPTY: begin
        info_o.field_type = TYPE_NULL;
      end
      CLS_INT: begin
        info_o.field_type = TYPE_INT;
        if (neg_q) begin
          if (ovf_q || (acc_q > MAG_LIMIT)) begin
            info_o.integer_value   = MAG_LIMIT;
            info_o.value_saturated = 1'b1;
          end else begin
            info_o.integer_value = 64'd0 - acc_q;
          end
        end else begin
          if (ovf_q || acc_q[63]) begin
            info_o.integer_value   = POS_MAX;
            info_o.value_saturated = 1'b1;
          end else begin
            info_o.integer_value = acc_q;
          end
        end
      end
      CLS_FRAC, CLS_EXP, CLS_EXPTAIL: begin
        info_o.field_type = TYPE_FLOAT;
      end
      CLS_TRUE: begin
        if (prog_q == TRUE_LEN) begin
          info_o.field_type    = TYPE_BOOL;
          info_o.boolean_value = 1'b1;
        end
      end
      CLS_FALSE: begin
        if (prog_q == FALSE_LEN) begin
          info_o.field_type = TYPE_BOOL;
        end
      end
      default: begin
        info_o.field_type = TYPE_STRING;
      end
    endcase
  end

endmodule

[design/csv_field_split_and_type_classify_core.sv]
// Top level: CSV field splitter with input register, row control and result register.
//
//   Channel | Direction | Handshake               | Payload
//   --------+-----------+-------------------------+------------------------------
//   in      | input     | in_valid_i / in_ready_o | in_data_i  (op, data_byte)
//   out     | output    | out_valid_o/out_ready_i | out_data_o (column, type, value)
//
// One byte is taken per cycle while the input is not stalled; a field result is
// registered when the byte that closes it leaves the input register.
// The per-byte state update and the multiply-by-ten accumulate sit between the
// input register and the result register, so throughput is one item per cycle.
// Input stalls only while the result register is full and not being taken.
// Reset clears quote, column and line state and leaves the field empty.
`timescale 1ns / 1ps

module csv_field_split_and_type_classify_core
  import csv_fs_pkg::*;
#(
  parameter int COLUMN_BITS = 8
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  csv_fs_in_t  in_data_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output csv_fs_out_t out_data_o
);

  // Input register.
  logic        in_valid_q;
  csv_fs_in_t  in_q;
  logic        proc;

  // Row state.
  logic                   inq_q, inq_d;
  logic                   skip_q, skip_d;
  logic [COLUMN_BITS-1:0] col_q, col_d;
  logic                   line_open_q, line_open_d;

  // Result register.
  logic        out_valid_q;
  csv_fs_out_t out_q;

  logic        is_eol, is_nl, is_split, is_quote;
  logic        emit, last, step;
  field_info_t info;
  logic [15:0] col_ext;

  // The item in the input register advances when the result register has room.
  assign proc       = in_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !in_valid_q || proc;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      in_q <= in_data_i;
    end
  end

  // Decode the registered item.
  assign is_eol   = (in_q.op == OP_EOL);
  assign is_nl    = !is_eol && (in_q.data_byte == CH_NEWLINE);
  assign is_split = !is_eol && (in_q.data_byte == CH_COMMA) && !inq_q;
  assign is_quote = !is_eol && (in_q.data_byte == CH_QUOTE);
  assign emit     = (is_eol && line_open_q) || is_nl || is_split;
  assign last     = !is_split;
  assign step     = proc && !is_eol && !is_nl && !is_split;

  // Quote, column and line tracking.
  always_comb begin
    inq_d       = inq_q;
    skip_d      = skip_q;
    col_d       = col_q;
    line_open_d = line_open_q;
    if (is_eol) begin
      if (line_open_q) begin
        inq_d       = 1'b0;
        skip_d      = 1'b0;
        col_d       = '0;
        line_open_d = 1'b0;
      end
    end else if (is_nl) begin
      inq_d       = 1'b0;
      skip_d      = 1'b0;
      col_d       = '0;
      line_open_d = 1'b0;
    end else begin
      line_open_d = 1'b1;
      if (is_split) begin
        skip_d = 1'b0;
        if (col_q != '1) begin
          col_d = col_q + COLUMN_BITS'(1);
        end
      end else if (is_quote) begin
        if (skip_q) begin
          skip_d = 1'b0;
        end else begin
          inq_d  = !inq_q;
          skip_d = 1'b1;
        end
      end else begin
        skip_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      inq_q       <= 1'b0;
      skip_q      <= 1'b0;
      col_q       <= '0;
      line_open_q <= 1'b0;
    end else if (proc) begin
      inq_q       <= inq_d;
      skip_q      <= skip_d;
      col_q       <= col_d;
      line_open_q <= line_open_d;
    end
  end

  // Field classifier.
  csv_fs_field u_field (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .step_i  (step),
    .clear_i (proc && emit),
    .byte_i  (in_q.data_byte),
    .info_o  (info)
  );

  // Column number widened, then cut to the 8-bit output field.
  assign col_ext = 16'(col_q);

  // Result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (proc && emit) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (proc && emit) begin
      out_q.column_index    <= col_ext[7:0];
      out_q.last_in_row     <= last;
      out_q.field_type      <= info.field_type;
      out_q.integer_value   <= info.integer_value;
      out_q.value_saturated <= info.value_saturated;
      out_q.boolean_value   <= info.boolean_value;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

[design/csv_fs_checker.sv]
// Port-level checker for the CSV field splitter, bound to the top level.
`timescale 1ns / 1ps

module csv_fs_checker
  import csv_fs_pkg::*;
(
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_ready_o,
  input logic        out_valid_o,
  input logic        out_ready_i,
  input csv_fs_out_t out_data_o
);

  // A stalled result holds its payload until it is transferred.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i) |=> (out_valid_o && $stable(out_data_o)))
    else $error("result changed while stalled");

  // The input side only stalls when a result is waiting and not taken.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> (out_valid_o && !out_ready_i))
    else $error("input stalled without output back-pressure");

  // Only integer fields carry a value or a saturation mark.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (out_data_o.field_type != TYPE_INT)) |->
      ((out_data_o.integer_value == 64'sd0) && !out_data_o.value_saturated))
    else $error("non-integer field carries integer value");

  // A saturated integer is clamped to one end of the 64-bit range, and a true
  // flag only comes with a boolean field.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_data_o.value_saturated) |->
      ((out_data_o.integer_value == MAG_LIMIT) || (out_data_o.integer_value == POS_MAX)))
    else $error("saturated integer not at range limit");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_data_o.boolean_value) |-> (out_data_o.field_type == TYPE_BOOL))
    else $error("boolean flag on non-boolean field");

endmodule

bind csv_field_split_and_type_classify_core csv_fs_checker u_csv_fs_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_ready_o  (in_ready_o),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_data_o  (out_data_o)
);
